// ===== hdl/xrng_pkg.sv =====
// shared types, constants and helper functions for the xoshiro256** rng unit
// no dependencies; used by every module under hdl

package xrng_pkg;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] SM_MUL_A     = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] SM_MUL_B     = 64'h94D049BB133111EB;
	localparam logic [63:0] ACC_A_INIT   = 64'h243F6A8885A308D3;
	localparam logic [63:0] ACC_B_INIT   = 64'h13198A2E03707344;
	localparam logic [63:0] BYTE_MUL     = 64'hA0761D6478BD642F;

	localparam logic [5:0] ROT_GEN_OUT = 6'd7;
	localparam logic [5:0] ROT_GEN_S3  = 6'd45;
	localparam logic [5:0] ROT_MIX_A   = 6'd23;
	localparam logic [5:0] ROT_MIX_B   = 6'd41;
	localparam int unsigned GEN_SHIFT  = 17;

	// input word commands
	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_MIX  = 1'b1;

	// command word from controller to datapath
	typedef struct packed {
		logic       load_item;
		logic       sm_add;
		logic       mul_run;
		logic       mul_sel_b;
		logic [1:0] sm_idx;
		logic       gen1;
		logic       gen2;
		logic       gen_emit;
		logic       mix1;
		logic       mix_port;
		logic       mix2;
		logic       fold;
	} xrng_cmd_t;

	// status from datapath back to controller
	typedef struct packed {
		logic mul_done;
	} xrng_stat_t;

	// rotate left, a rotation by zero returns the operand
	function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
		logic [6:0] rc;
		rc = 7'd64 - {1'b0, r};
		if (r == 6'd0)
			return x;
		return (x << r) | (x >> rc);
	endfunction

endpackage

// ===== hdl/xrng_mul.sv =====
// 64x64 truncated multiply by a splitmix constant, in phases lo, x1 and x2 on one 32x32 multiplier
// depends on xrng_pkg

module xrng_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        run,
	input  logic        sel_b,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] product
);

	localparam logic [1:0] PH_LO  = 2'd0;
	localparam logic [1:0] PH_X1  = 2'd1;
	localparam logic [1:0] PH_X2  = 2'd2;

	logic [1:0]  phase_q;
	logic [63:0] lo_q;
	logic [31:0] hi_q;
	logic [63:0] k;
	logic [31:0] op_a;
	logic [31:0] op_k;
	logic [63:0] pp;

	assign k = sel_b ? xrng_pkg::SM_MUL_B : xrng_pkg::SM_MUL_A;

	always_comb begin
		op_a = a[31:0];
		op_k = k[31:0];
		case (phase_q)
			PH_X1: op_a = a[63:32];
			PH_X2: op_k = k[63:32];
			default: ;
		endcase
	end

	assign pp      = {32'd0, op_a} * {32'd0, op_k};
	assign done    = run && (phase_q == PH_X2);
	assign product = {hi_q + pp[31:0], lo_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LO;
		end else if (!run || phase_q == PH_X2) begin
			phase_q <= PH_LO;
		end else begin
			phase_q <= phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run && phase_q == PH_LO) begin
			lo_q <= pp;
		end
		if (run && phase_q == PH_X1) begin
			hi_q <= lo_q[63:32] + pp[31:0];
		end
	end

endmodule

// ===== hdl/xrng_dp.sv =====
// datapath: generator state, mix accumulators, splitmix seeding registers, output word
// depends on xrng_pkg and xrng_mul

module xrng_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  xrng_pkg::xrng_cmd_t cmd_in,
	output xrng_pkg::xrng_stat_t stat,
	input  logic [7:0]          entropy_byte,
	input  logic [63:0]         seed_sample,
	output logic [63:0]         random_word
);

	logic [63:0] s_q [4];
	logic [63:0] acc_a_q;
	logic [63:0] acc_b_q;
	logic [63:0] ctr_q;
	logic [63:0] z_q;
	logic [63:0] prod_q;
	logic [63:0] bp_q;
	logic [7:0]  byte_q;
	logic [63:0] word_q;

	logic        mul_done;
	logic [63:0] mul_p;
	logic [63:0] ctr_n;
	logic [7:0]  v;
	logic [63:0] acc_a_n;
	logic [63:0] n2, n3, gen_r;

	xrng_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.run     (cmd_in.mul_run),
		.sel_b   (cmd_in.mul_sel_b),
		.a       (z_q),
		.done    (mul_done),
		.product (mul_p)
	);

	assign stat.mul_done = mul_done;
	assign random_word   = word_q;

	assign ctr_n   = ctr_q + xrng_pkg::GOLDEN_GAMMA;
	assign v       = cmd_in.mix_port ? entropy_byte : byte_q;
	assign acc_a_n = acc_a_q ^ ({56'd0, v} + xrng_pkg::GOLDEN_GAMMA
		+ (acc_a_q << 6) + (acc_a_q >> 2));
	assign n2      = s_q[2] ^ s_q[0];
	assign n3      = s_q[3] ^ s_q[1];
	assign gen_r   = xrng_pkg::rotl64(prod_q, xrng_pkg::ROT_GEN_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q <= xrng_pkg::ACC_A_INIT;
			acc_b_q <= xrng_pkg::ACC_B_INIT;
		end else if (cmd_in.fold) begin
			acc_a_q <= xrng_pkg::ACC_A_INIT;
			acc_b_q <= xrng_pkg::ACC_B_INIT;
		end else begin
			if (cmd_in.mix1) begin
				acc_a_q <= acc_a_n;
			end
			if (cmd_in.mix2) begin
				acc_b_q <= acc_b_q ^ (acc_a_q + bp_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.load_item) begin
			byte_q <= entropy_byte;
			ctr_q  <= seed_sample;
		end
		if (cmd_in.sm_add) begin
			ctr_q <= ctr_n;
			z_q   <= ctr_n ^ (ctr_n >> 30);
		end
		if (cmd_in.mul_run && mul_done && !cmd_in.mul_sel_b) begin
			z_q <= mul_p ^ (mul_p >> 27);
		end
		if (cmd_in.mul_run && mul_done && cmd_in.mul_sel_b) begin
			s_q[cmd_in.sm_idx] <= mul_p ^ (mul_p >> 31);
		end
		if (cmd_in.gen1) begin
			prod_q <= s_q[1] + (s_q[1] << 2);
		end
		if (cmd_in.mix1) begin
			bp_q <= xrng_pkg::rotl64({56'd0, v} * xrng_pkg::BYTE_MUL, v[5:0]);
		end
		if (cmd_in.gen2) begin
			s_q[0] <= s_q[0] ^ n3;
			s_q[1] <= s_q[1] ^ n2;
			s_q[2] <= n2 ^ (s_q[1] << xrng_pkg::GEN_SHIFT);
			s_q[3] <= xrng_pkg::rotl64(n3, xrng_pkg::ROT_GEN_S3);
		end
		if (cmd_in.gen_emit) begin
			word_q <= gen_r + (gen_r << 3);
		end
		if (cmd_in.fold) begin
			s_q[0] <= s_q[0] ^ acc_a_q;
			s_q[1] <= s_q[1] ^ acc_b_q;
			s_q[2] <= s_q[2] ^ xrng_pkg::rotl64(acc_a_q, xrng_pkg::ROT_MIX_A);
			s_q[3] <= s_q[3] ^ xrng_pkg::rotl64(acc_b_q, xrng_pkg::ROT_MIX_B);
		end
	end

endmodule

// ===== hdl/xrng_ctrl.sv =====
// controller: sequences seeding, generator steps and mix runs, owns both handshakes
// depends on xrng_pkg

module xrng_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output xrng_pkg::xrng_cmd_t  cmd_out,
	input  xrng_pkg::xrng_stat_t stat
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SM_ADD,
		ST_SM_MULA,
		ST_SM_MULB,
		ST_GEN1,
		ST_GEN2,
		ST_MIX1,
		ST_MIX2,
		ST_FOLD
	} state_t;

	state_t     state_q;
	logic       seeded_q;
	logic       cmd_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;
	logic       is_mix;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign is_mix    = (cmd == xrng_pkg::CMD_MIX);

	always_comb begin
		cmd_out           = '0;
		cmd_out.sm_idx    = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd_out.load_item = accept;
				cmd_out.gen1      = accept && seeded_q && !is_mix;
				cmd_out.mix1      = accept && seeded_q && is_mix;
				cmd_out.mix_port  = 1'b1;
			end
			ST_SM_ADD:  cmd_out.sm_add = 1'b1;
			ST_SM_MULA: cmd_out.mul_run = 1'b1;
			ST_SM_MULB: begin
				cmd_out.mul_run   = 1'b1;
				cmd_out.mul_sel_b = 1'b1;
			end
			ST_GEN1: cmd_out.gen1 = 1'b1;
			ST_GEN2: begin
				cmd_out.gen2     = cmd_q || out_free;
				cmd_out.gen_emit = !cmd_q && out_free;
			end
			ST_MIX1: cmd_out.mix1 = 1'b1;
			ST_MIX2: cmd_out.mix2 = 1'b1;
			ST_FOLD: cmd_out.fold = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			cmd_q       <= 1'b0;
			last_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word lands in the output register, or the pending one is taken
			if (cmd_out.gen_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q  <= is_mix;
						last_q <= last_byte;
						idx_q  <= 2'd0;
						if (!seeded_q) begin
							state_q <= ST_SM_ADD;
						end else if (is_mix) begin
							state_q <= ST_MIX2;
						end else begin
							state_q <= ST_GEN2;
						end
					end
				end
				ST_SM_ADD: state_q <= ST_SM_MULA;
				ST_SM_MULA: begin
					if (stat.mul_done) begin
						state_q <= ST_SM_MULB;
					end
				end
				ST_SM_MULB: begin
					if (stat.mul_done) begin
						if (idx_q == 2'd3) begin
							seeded_q <= 1'b1;
							state_q  <= cmd_q ? ST_MIX1 : ST_GEN1;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_SM_ADD;
						end
					end
				end
				ST_GEN1: state_q <= ST_GEN2;
				ST_GEN2: begin
					if (cmd_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MIX1: state_q <= ST_MIX2;
				ST_MIX2: state_q <= last_q ? ST_FOLD : ST_IDLE;
				ST_FOLD: state_q <= ST_GEN1;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a new word is only written into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_out.gen_emit |-> (!out_valid_q || out_ready))
		else $error("output word overwritten while still pending");

	// entropy is only mixed into a seeded generator
	a_mix_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_out.mix1 |-> seeded_q)
		else $error("mix issued before seeding");

	// once seeded the generator never reseeds
	a_seeded_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |=> seeded_q)
		else $error("seeded flag dropped");

	// a fold is always followed by the discarded generator step
	a_fold_then_gen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_out.fold |=> cmd_out.gen1)
		else $error("fold not followed by generator step");

endmodule

// ===== hdl/xoshiro256ss_mixing_rng_unit.sv =====
// top level of the xoshiro256** rng unit with entropy mixing
// depends on xrng_pkg, xrng_ctrl, xrng_dp (which holds xrng_mul)

// The unit keeps a 256-bit xoshiro256** state and two 64-bit mix accumulators.
// Both channels are valid/ready; a word is taken when valid and ready are high
// at a rising edge. The first word after reset seeds the state, whatever its
// cmd: splitmix64 runs four times from seed_sample, once per state word, on
// one shared 32x32 multiplier (each 64-bit constant multiply takes three passes);
// seed_sample is ignored after. A read word (cmd 0) yields one random_word,
// held in an output register so the next input word can be taken while it waits;
// a read stalls only if the previous random_word has still not been taken. A mix
// word (cmd 1) folds entropy_byte into the accumulators and gives no output; with
// last_byte set it then folds the accumulators into the state, reloading them,
// and runs one discarded generator step. Reads between mix words leave a mix run
// untouched. The unit handles one word at a time; in_ready is high only while it
// is idle.

module xoshiro256ss_mixing_rng_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  entropy_byte,
	input  logic        last_byte,
	input  logic [63:0] seed_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] random_word
);

	// command and status between sequencer and datapath
	xrng_pkg::xrng_cmd_t  dp_cmd;
	xrng_pkg::xrng_stat_t dp_stat;

	// sequencer: handshakes, seeding loop, step ordering
	xrng_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd_out   (dp_cmd),
		.stat      (dp_stat)
	);

	// datapath: state words, accumulators, multiplier, output register
	xrng_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_in       (dp_cmd),
		.stat         (dp_stat),
		.entropy_byte (entropy_byte),
		.seed_sample  (seed_sample),
		.random_word  (random_word)
	);

endmodule
